// ----- design/nvs_pkg.sv -----
// Package with shared widths, codes and state type of the nearest vector search unit.
package nvs_pkg;

   localparam int VALUE_W     = 16;
   localparam int ENTRY_IDX_W = 10;
   localparam int ELEM_IDX_W  = 7;
   localparam int DIST_W      = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int VLEN_W      = 8;
   localparam int WCOUNT_W    = 11;
   localparam int THRESH_SHIFT = 25;

   localparam logic [VLEN_W-1:0]   VLEN_RESET   = 8'd100;
   localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = 11'd0;

   localparam logic [CSR_INDEX_W-1:0] CSR_VECTOR_LENGTH = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_COUNT    = 8'd1;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// ----- design/nearest_vector_search_unit.sv -----
// Top level of the nearest vector search unit: table, query buffer, sequencer and MAC pipeline.
//
//  channel   direction  handshake            payload
//  req_*     in         start & !busy        command, entry_index, element_index, value, last
//  rsp_*     out        rsp_valid strobe     found, best_index, best_distance
//  csr_*     in         csr_valid&csr_ready  index, wdata
//
// A load item or a query item without last leaves busy low.
// A query item with last keeps busy high while the single subtract-square-accumulate unit
// walks word_count * vector_length elements (effective, saturated values), one element
// per cycle; the result strobe comes in the last busy cycle.
// With a zero length or zero count no element is walked and the result is not found.
// Synchronous reset clears the sequencer, CSRs and valid flags, not the memories or datapath.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module nearest_vector_search_unit
   import nvs_pkg::*;
#(
   parameter int MAX_ENTRIES = 1024,
   parameter int MAX_LENGTH  = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_command,
   input  logic [ENTRY_IDX_W-1:0]     req_entry_index,
   input  logic [ELEM_IDX_W-1:0]      req_element_index,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic                       req_last,
   output logic                       rsp_valid,
   output logic                       rsp_found,
   output logic [ENTRY_IDX_W-1:0]     rsp_best_index,
   output logic [DIST_W-1:0]          rsp_best_distance,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int LW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int NW = $clog2(MAX_LENGTH + 1);
   localparam int TABLE_DEPTH = MAX_ENTRIES * (2 ** LW);
   localparam int SQ_W  = 2 * VALUE_W;
   localparam int ACC_W = SQ_W + NW;

   state_type state_ff, state_in;

   logic [VLEN_W-1:0]   vlen_ff;
   logic [WCOUNT_W-1:0] wcount_ff;

   logic [NW-1:0] n_ff, n_eff;
   logic [CW-1:0] cnt_ff, cnt_eff;
   logic [EW-1:0] e_ff;
   logic [LW-1:0] i_ff;

   logic                      s1_valid_ff, s1_end_ff;
   logic [EW-1:0]             s1_entry_ff;
   logic signed [VALUE_W-1:0] q_rd_ff, t_rd_ff;
   logic                      s2_valid_ff, s2_end_ff;
   logic [EW-1:0]             s2_entry_ff;
   logic [SQ_W-1:0]           sq_ff;

   logic [ACC_W-1:0] acc_ff, best_ff, sum;
   logic [EW-1:0]    best_idx_ff;
   logic             found_ff;

   logic signed [VALUE_W:0] diff;
   logic [VALUE_W-1:0]      abs_diff;

   logic accept, go, load_we, query_we, issue, row_end, entry_end, issue_last;

   logic signed [VALUE_W-1:0] table_mem [0:TABLE_DEPTH-1];
   logic signed [VALUE_W-1:0] qbuf_mem  [0:MAX_LENGTH-1];

   assign csr_ready = 1'b1;

   assign accept   = start && !busy;
   assign load_we  = accept && (req_command == CMD_LOAD)
                     && (32'(req_entry_index) < MAX_ENTRIES)
                     && (32'(req_element_index) < MAX_LENGTH);
   assign query_we = accept && (req_command == CMD_QUERY)
                     && (32'(req_element_index) < MAX_LENGTH);
   assign go       = accept && (req_command == CMD_QUERY) && req_last;

   assign n_eff   = (32'(vlen_ff) > MAX_LENGTH) ? NW'(MAX_LENGTH) : NW'(vlen_ff);
   assign cnt_eff = (32'(wcount_ff) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(wcount_ff);

   assign row_end    = (NW'(i_ff) + NW'(1)) == n_ff;
   assign entry_end  = (CW'(e_ff) + CW'(1)) == cnt_ff;
   assign issue_last = row_end && entry_end;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = ((n_eff == '0) || (cnt_eff == '0)) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = 1'b1;
      issue     = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_RUN:   issue = 1'b1;
         ST_DRAIN: issue = 1'b0;
         ST_DONE:  rsp_valid = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         vlen_ff     <= VLEN_RESET;
         wcount_ff   <= WCOUNT_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_VECTOR_LENGTH) begin
               vlen_ff <= csr_wdata[VLEN_W-1:0];
            end else if (csr_index == CSR_WORD_COUNT) begin
               wcount_ff <= csr_wdata[WCOUNT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         table_mem[{EW'(req_entry_index), LW'(req_element_index)}] <= req_value;
      end
      t_rd_ff <= table_mem[{e_ff, i_ff}];
   end

   always_ff @(posedge clock) begin
      if (query_we) begin
         qbuf_mem[LW'(req_element_index)] <= req_value;
      end
      q_rd_ff <= qbuf_mem[i_ff];
   end

   assign diff     = (VALUE_W + 1)'(q_rd_ff) - (VALUE_W + 1)'(t_rd_ff);
   assign abs_diff = diff[VALUE_W] ? VALUE_W'(-diff) : VALUE_W'(diff);
   assign sum      = acc_ff + ACC_W'(sq_ff);

   always_ff @(posedge clock) begin
      s1_end_ff   <= row_end;
      s1_entry_ff <= e_ff;
      s2_end_ff   <= s1_end_ff;
      s2_entry_ff <= s1_entry_ff;
      sq_ff       <= abs_diff * abs_diff;
      if (go) begin
         n_ff        <= n_eff;
         cnt_ff      <= cnt_eff;
         e_ff        <= '0;
         i_ff        <= '0;
         acc_ff      <= '0;
         best_ff     <= ACC_W'(n_eff) << THRESH_SHIFT;
         best_idx_ff <= '0;
         found_ff    <= 1'b0;
      end else begin
         if (issue) begin
            if (row_end) begin
               i_ff <= '0;
               e_ff <= e_ff + EW'(1);
            end else begin
               i_ff <= i_ff + LW'(1);
            end
         end
         if (s2_valid_ff) begin
            if (s2_end_ff) begin
               acc_ff <= '0;
               if (sum < best_ff) begin
                  best_ff     <= sum;
                  best_idx_ff <= s2_entry_ff;
                  found_ff    <= 1'b1;
               end
            end else begin
               acc_ff <= sum;
            end
         end
      end
   end

   assign rsp_found         = found_ff;
   assign rsp_best_index    = found_ff ? ENTRY_IDX_W'(best_idx_ff) : '0;
   assign rsp_best_distance = !found_ff ? '0 :
                              (best_ff > ACC_W'(32'hFFFF_FFFF)) ? '1 : best_ff[DIST_W-1:0];

endmodule

// ----- design/nvs_checker.sv -----
// Port-level assertion checker for the nearest vector search unit, with its bind statement.
module nvs_checker
   import nvs_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   req_command,
   input logic                   rsp_valid,
   input logic                   rsp_found,
   input logic [ENTRY_IDX_W-1:0] rsp_best_index,
   input logic [DIST_W-1:0]      rsp_best_distance
);

   a_strobe_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while not busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_best_index == '0 && rsp_best_distance == '0))
      else $error("not-found result carries nonzero fields");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_LOAD)) |=> !rsp_valid && !busy)
      else $error("load item caused a result or busy");

endmodule

bind nearest_vector_search_unit nvs_checker u_nvs_checker (.*);
